// ===== src/ntio_pkg.sv =====
// Package for the I/O node lookup pipeline.
// Item record, configuration record and the per-stage step function.
// No dependencies.
`default_nettype none
package ntio_pkg;

  localparam int unsigned NDim       = 4;
  localparam int unsigned RegW       = 9;
  localparam int unsigned NodeW      = 32;
  localparam int unsigned DivStages  = 8;   // stages per 32-bit coordinate split
  localparam int unsigned DivSteps   = 4;   // quotient bits per stage
  localparam int unsigned BlkSteps   = 3;   // quotient bits per stage, 9-bit divides
  localparam int unsigned RoundStart = NDim * DivStages;        // 32
  localparam int unsigned MulStage   = RoundStart + 3;          // 35
  localparam int unsigned LinStage   = MulStage + 1;            // 36
  localparam int unsigned NStages    = LinStage + 3;            // 39
  localparam logic [2:0]  IdxParts   = 3'd4;

  typedef struct packed {
    logic [NDim-1:0][RegW-1:0] ext;
    logic [NDim-1:0][RegW-1:0] prt;
  } cfg_t;

  typedef struct packed {
    logic [NodeW-1:0]          node;
    logic                      bad;
    logic [NodeW-1:0]          num;    // dividend, turning into quotient
    logic [RegW-1:0]           rem;    // partial remainder
    logic [NDim-1:0][RegW-1:0] coord;
    logic [NDim-1:0][RegW-1:0] blk;    // extent / parts, then per-lane divisor
    logic [NDim-1:0][RegW-1:0] brem;
    logic [NodeW-1:0]          rank;
  } item_t;

  function automatic item_t stage_f(input int unsigned s, input item_t i, input cfg_t cfg);
    item_t       o;
    logic [RegW:0] t;
    logic [1:0]  d;
    logic        anybad;
    o = i;
    d = 2'(s / DivStages);
    anybad = 1'b0;
    if (s < RoundStart) begin
      if (s == 0) begin
        o.num = o.node;
        for (int l = 0; l < NDim; l++) begin
          o.blk[l]  = cfg.ext[l];
          o.brem[l] = '0;
        end
      end
      if ((s % DivStages) == 0) o.rem = '0;
      // restoring division of the running quotient by the current extent
      for (int k = 0; k < DivSteps; k++) begin
        t = {o.rem, o.num[NodeW-1]};
        o.num = {o.num[NodeW-2:0], 1'b0};
        if (t >= {1'b0, cfg.ext[d]}) begin
          o.rem    = RegW'(t - {1'b0, cfg.ext[d]});
          o.num[0] = 1'b1;
        end else begin
          o.rem = t[RegW-1:0];
        end
      end
      // block size and divisibility check, lanes in parallel
      if (s < 3) begin
        for (int l = 0; l < NDim; l++) begin
          for (int k = 0; k < BlkSteps; k++) begin
            t = {o.brem[l], o.blk[l][RegW-1]};
            o.blk[l] = {o.blk[l][RegW-2:0], 1'b0};
            if (t >= {1'b0, cfg.prt[l]}) begin
              o.brem[l]   = RegW'(t - {1'b0, cfg.prt[l]});
              o.blk[l][0] = 1'b1;
            end else begin
              o.brem[l] = t[RegW-1:0];
            end
          end
        end
      end
      if (s == 2) begin
        for (int l = 0; l < NDim; l++) begin
          if (cfg.ext[l] == '0 || cfg.prt[l] == '0 || o.brem[l] != '0) anybad = 1'b1;
        end
        o.bad = anybad;
      end
      if ((s % DivStages) == DivStages - 1) o.coord[d] = o.rem;
    end else if (s < MulStage) begin
      if (s == RoundStart) begin
        for (int l = 0; l < NDim; l++) o.brem[l] = '0;
      end
      for (int l = 0; l < NDim; l++) begin
        for (int k = 0; k < BlkSteps; k++) begin
          t = {o.brem[l], o.coord[l][RegW-1]};
          o.coord[l] = {o.coord[l][RegW-2:0], 1'b0};
          if (t >= {1'b0, o.blk[l]}) begin
            o.brem[l]     = RegW'(t - {1'b0, o.blk[l]});
            o.coord[l][0] = 1'b1;
          end else begin
            o.brem[l] = t[RegW-1:0];
          end
        end
      end
    end else if (s == MulStage) begin
      for (int l = 0; l < NDim; l++) o.coord[l] = RegW'(o.coord[l] * o.blk[l]);
    end else if (s == LinStage) begin
      o.rank = NodeW'(o.coord[3] * cfg.ext[2] + {9'd0, o.coord[2]});
    end else if (s == LinStage + 1) begin
      o.rank = NodeW'(o.rank * cfg.ext[1] + {23'd0, o.coord[1]});
    end else begin
      o.rank = NodeW'(o.rank * cfg.ext[0] + {23'd0, o.coord[0]});
      if (o.bad) o.rank = o.node;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== src/ntio_if.sv =====
// Handshake channels for the I/O node lookup: node in, I/O node out.
// No dependencies.
`default_nettype none
interface ntio_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] node;
  modport source (output valid, output node, input ready);
  modport sink   (input valid, input node, output ready);
endinterface

interface ntio_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] io_node_number;
  logic        geometry_error;
  modport source (output valid, output io_node_number, output geometry_error, input ready);
  modport sink   (input valid, input io_node_number, input geometry_error, output ready);
endinterface
`default_nettype wire

// ===== src/ntio_stage.sv =====
// One register stage of the lookup pipeline.
// Depends on ntio_pkg (item record and step function).
`default_nettype none
module ntio_stage #(
  parameter int unsigned Stage = 0
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             adv_i,
  input  wire             valid_i,
  input  ntio_pkg::item_t item_i,
  input  ntio_pkg::cfg_t  cfg_i,
  output logic            valid_o,
  output ntio_pkg::item_t item_o
);
  logic            valid_q;
  ntio_pkg::item_t item_q, item_d;

  assign item_d = ntio_pkg::stage_f(Stage, item_i, cfg_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule
`default_nettype wire

// ===== src/node_to_io_partition_origin.sv =====
// Top level of the I/O node lookup.
// Depends on ntio_pkg, ntio_if and ntio_stage.
//
// Maps a linear node number to the node at the origin of its I/O partition.
// One item per cycle; the whole pipe stalls together while the output is held.
// The depth comes from the bit-serial splits into coordinates (four quotient
// bits a stage, 32 stages), three stages rounding to the partition size, one
// stage scaling back by the partition size and three multiply-add stages.
// If any extent or partition count is zero, or an extent is not a multiple of
// its partition count, the error flag is set and the node number comes back unchanged.
`default_nettype none
module node_to_io_partition_origin (
  input  wire              clk_i,
  input  wire              rst_ni,
  ntio_in_if.sink          in_i,
  ntio_out_if.source       out_o,
  input  wire              cfg_we_i,
  input  wire [2:0]        cfg_idx_i,
  input  wire [8:0]        cfg_data_i
);
  localparam int unsigned N = ntio_pkg::NStages;

  ntio_pkg::cfg_t  cfg_q;
  logic [N:0]      v;
  ntio_pkg::item_t it [N+1];
  logic            adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < ntio_pkg::NDim; l++) begin
        cfg_q.ext[l] <= 9'd1;
        cfg_q.prt[l] <= 9'd1;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i < ntio_pkg::IdxParts) cfg_q.ext[cfg_idx_i[1:0]] <= cfg_data_i;
      else                                cfg_q.prt[cfg_idx_i[1:0]] <= cfg_data_i;
    end
  end

  assign adv        = !v[N] || out_o.ready;
  assign in_i.ready = adv;

  always_comb begin
    it[0]      = '0;
    it[0].node = in_i.node;
  end
  assign v[0] = in_i.valid;

  for (genvar s = 0; s < N; s++) begin : g_stage
    ntio_stage #(.Stage(s)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (v[s]),
      .item_i  (it[s]),
      .cfg_i   (cfg_q),
      .valid_o (v[s+1]),
      .item_o  (it[s+1])
    );
  end

  assign out_o.valid          = v[N];
  assign out_o.io_node_number = it[N].rank;
  assign out_o.geometry_error = it[N].bad;
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for node_to_io_partition_origin: random and directed node numbers
// under a series of grid geometries, checked against an in-bench prediction.
// Depends on ntio_pkg, ntio_if and the RTL of the lookup.
`default_nettype none
module testbench;

  typedef struct {
    logic [31:0] io_node;
    logic        geo_err;
  } io_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [8:0] cfg_data = '0;

  ntio_in_if  in_if ();
  ntio_out_if out_if ();

  node_to_io_partition_origin dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // local copy of the geometry registers
  logic [8:0] grid_ext [ntio_pkg::NDim];
  logic [8:0] grid_prt [ntio_pkg::NDim];

  logic [31:0] node_q [$];
  io_result_t  origin_q [$];
  int unsigned n_in = 0, n_out = 0, n_err = 0, n_fail = 0, n_geo = 0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  function automatic io_result_t io_origin_of(input logic [31:0] node);
    io_result_t       res;
    longint unsigned  rest, blk, c, rank;
    longint unsigned  crd [ntio_pkg::NDim];
    bit               bad;
    bad = 1'b0;
    for (int d = 0; d < ntio_pkg::NDim; d++)
      if (grid_ext[d] == 0 || grid_prt[d] == 0 || (grid_ext[d] % grid_prt[d]) != 0) bad = 1'b1;
    if (bad) begin
      res.io_node = node;
      res.geo_err = 1'b1;
      return res;
    end
    rest = node;
    for (int d = 0; d < ntio_pkg::NDim; d++) begin
      blk = grid_ext[d] / grid_prt[d];
      c = rest % grid_ext[d];
      rest = rest / grid_ext[d];
      crd[d] = (c / blk) * blk;
    end
    rank = crd[3];
    for (int d = 2; d >= 0; d--) rank = rank * grid_ext[d] + crd[d];
    res.io_node = rank[31:0];
    res.geo_err = 1'b0;
    return res;
  endfunction

  // sender: no idling while items 300..499 go in
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.node  <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (node_q.size() > 0 &&
          !(($urandom_range(0, 99) < 19) && !(n_in >= 300 && n_in < 500))) begin
        in_if.valid <= 1'b1;
        in_if.node  <= node_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: one long hold-off once 700 items are in, so the pipe fills
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (!hold_done && n_in >= 700) begin
      hold_done    <= 1'b1;
      hold_left    <= 150;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(($urandom_range(0, 99) < 19) && !(n_in >= 300 && n_in < 500));
    end
  end

  always @(posedge clk_i) begin
    io_result_t want;
    if (rst_ni && in_if.valid && in_if.ready) begin
      origin_q.push_back(io_origin_of(in_if.node));
      n_in <= n_in + 1;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_out = n_out + 1;
      if (origin_q.size() == 0) begin
        $error("result with nothing expected: %h", out_if.io_node_number);
        n_fail = n_fail + 1;
      end else begin
        want = origin_q.pop_front();
        if (want.geo_err) n_geo = n_geo + 1;
        if (out_if.io_node_number !== want.io_node) begin
          $error("io_node_number: expected %h, got %h", want.io_node, out_if.io_node_number);
          n_fail = n_fail + 1;
        end
        if (out_if.geometry_error !== want.geo_err) begin
          $error("geometry_error: expected %b, got %b", want.geo_err, out_if.geometry_error);
          n_fail = n_fail + 1;
        end
      end
    end
  end

  task automatic wait_drained();
    while (node_q.size() > 0 || in_if.valid || origin_q.size() > 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [8:0] e0, e1, e2, e3, p0, p1, p2, p3);
    logic [8:0] vals [2*ntio_pkg::NDim];
    vals = '{e0, e1, e2, e3, p0, p1, p2, p3};
    for (int i = 0; i < 2 * ntio_pkg::NDim; i++) begin
      @(posedge clk_i);
      cfg_we   <= 1'b1;
      cfg_idx  <= 3'(i);
      cfg_data <= vals[i];
      if (i < ntio_pkg::NDim) grid_ext[i] = vals[i];
      else grid_prt[i - ntio_pkg::NDim] = vals[i];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_node();
    longint unsigned span;
    span = 1;
    for (int d = 0; d < ntio_pkg::NDim; d++)
      span = span * (grid_ext[d] == 0 ? 1 : grid_ext[d]);
    case ($urandom_range(0, 3))
      0, 1: return $urandom();
      2: return (span > 64'hFFFF_FFFF) ? $urandom() : 32'($urandom() % span);
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                            : 32'(1) << $urandom_range(0, 31);
    endcase
  endfunction

  // random commensurate geometry, mostly small extents
  task automatic random_geometry();
    logic [8:0] e [ntio_pkg::NDim];
    logic [8:0] p [ntio_pkg::NDim];
    int unsigned blk;
    for (int d = 0; d < ntio_pkg::NDim; d++) begin
      p[d] = 9'($urandom_range(1, 12));
      blk  = $urandom_range(1, 511 / p[d]);
      if ($urandom_range(0, 3) != 0 && blk > 6) blk = $urandom_range(1, 6);
      e[d] = 9'(p[d] * blk);
    end
    set_geometry(e[0], e[1], e[2], e[3], p[0], p[1], p[2], p[3]);
  endtask

  task automatic feed(input int unsigned count);
    for (int i = 0; i < count; i++) node_q.push_back(pick_node());
  endtask

  initial begin
    for (int d = 0; d < ntio_pkg::NDim; d++) begin
      grid_ext[d] = 9'd1;
      grid_prt[d] = 9'd1;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: reset geometry, then a mixed one with extreme node numbers
    node_q.push_back(32'h0);
    node_q.push_back(32'hFFFF_FFFF);
    wait_drained();
    set_geometry(9'd4, 9'd6, 9'd8, 9'd3, 9'd2, 9'd3, 9'd4, 9'd1);
    node_q = '{32'd0, 32'd1, 32'd5, 32'd23, 32'd24, 32'd575, 32'd576, 32'h8000_0000,
               32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'd143, 32'd200};
    wait_drained();
    set_geometry(9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256);
    node_q = '{32'd0, 32'hFFFF_FFFF, 32'h1234_5678};
    wait_drained();
    set_geometry(9'd511, 9'd511, 9'd511, 9'd511, 9'd7, 9'd1, 9'd511, 9'd73);
    node_q = '{32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'd0};
    wait_drained();
    // incommensurate, zero extent and zero parts
    set_geometry(9'd6, 9'd4, 9'd4, 9'd4, 9'd4, 9'd2, 9'd2, 9'd2);
    node_q = '{32'd7, 32'hFFFF_FFFF};
    wait_drained();
    set_geometry(9'd4, 9'd0, 9'd4, 9'd4, 9'd2, 9'd2, 9'd2, 9'd2);
    node_q.push_back(32'd99);
    wait_drained();
    set_geometry(9'd4, 9'd4, 9'd4, 9'd4, 9'd2, 9'd2, 9'd0, 9'd2);
    node_q.push_back(32'd99);
    wait_drained();
    // random phases, a few with broken geometry
    for (int ph = 0; ph < 14; ph++) begin
      if (ph % 5 == 4)
        set_geometry(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                     9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                     9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                     9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
      else if (ph == 7)
        set_geometry(9'd256, 9'd256, 9'd256, 9'd256, 9'd1, 9'd1, 9'd1, 9'd1);
      else
        random_geometry();
      feed(100);
      wait_drained();
    end
    $display("covered %0d items over 21 geometries, %0d with the geometry flag set",
             n_out, n_geo);
    if (n_fail == 0 && origin_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ===== node_to_io_partition_origin.f =====
src/ntio_pkg.sv
src/ntio_if.sv
src/ntio_stage.sv
src/node_to_io_partition_origin.sv
tb/testbench.sv
